/* rtl/keypad_fingerprint_lock_controller_defines.svh */
// Assertion macros shared by the lock controller checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef KEYPAD_FINGERPRINT_LOCK_CONTROLLER_DEFINES_SVH
`define KEYPAD_FINGERPRINT_LOCK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KFL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kfl assertion failed");

// Next-cycle implication, checked outside reset.
`define KFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kfl assertion failed");

`endif

/* rtl/kfl_pkg.sv */
// Shared types and constants of the keypad and fingerprint lock controller.
// Used by the controller, the datapath, the top level and the checker.
package kfl_pkg;

    // Fixed field widths.
    localparam int ID_W  = 9;
    localparam int IDV_W = 10;
    localparam int PC_W  = 4;

    // Request types.
    localparam logic [1:0] REQ_KEY   = 2'd0;
    localparam logic [1:0] REQ_MATCH = 2'd1;
    localparam logic [1:0] REQ_FAIL  = 2'd2;
    localparam logic [1:0] REQ_AUTO  = 2'd3;

    // Key codes.
    localparam logic [7:0] KEY_STAR = 8'h2A;
    localparam logic [7:0] KEY_0    = 8'h30;
    localparam logic [7:0] KEY_9    = 8'h39;
    localparam logic [7:0] KEY_A    = 8'h41;
    localparam logic [7:0] KEY_B    = 8'h42;
    localparam logic [7:0] KEY_C    = 8'h43;
    localparam logic [7:0] KEY_D    = 8'h44;

    // Modes.
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_FINGER = 3'd1;
    localparam logic [2:0] MODE_PIN    = 3'd2;
    localparam logic [2:0] MODE_MENU   = 3'd3;
    localparam logic [2:0] MODE_ENROLL = 3'd4;
    localparam logic [2:0] MODE_DELETE = 3'd5;

    // Status codes.
    localparam logic [3:0] STAT_NONE     = 4'd0;
    localparam logic [3:0] STAT_FINGER   = 4'd1;
    localparam logic [3:0] STAT_PIN      = 4'd2;
    localparam logic [3:0] STAT_MENU     = 4'd3;
    localparam logic [3:0] STAT_DIGIT    = 4'd4;
    localparam logic [3:0] STAT_CLEARED  = 4'd5;
    localparam logic [3:0] STAT_UNLOCKED = 4'd6;
    localparam logic [3:0] STAT_PIN_BAD  = 4'd7;
    localparam logic [3:0] STAT_FNG_BAD  = 4'd8;
    localparam logic [3:0] STAT_ENROLL   = 4'd9;
    localparam logic [3:0] STAT_ID_BAD   = 4'd10;
    localparam logic [3:0] STAT_DELETED  = 4'd11;
    localparam logic [3:0] STAT_MISSING  = 4'd12;
    localparam logic [3:0] STAT_AUTOLOCK = 4'd13;
    localparam logic [3:0] STAT_IDLE     = 4'd14;
    localparam logic [3:0] STAT_FULL     = 4'd15;

    // Configuration register indexes and reset values.
    localparam logic [1:0]  CFG_PIN_CHARS  = 2'd0;
    localparam logic [1:0]  CFG_PIN_LENGTH = 2'd1;
    localparam logic [1:0]  CFG_ID_LIMIT   = 2'd2;
    localparam logic [63:0] PIN_CHARS_RST  = 64'd875770417;
    localparam logic [3:0]  PIN_LENGTH_RST = 4'd4;
    localparam logic [8:0]  ID_LIMIT_RST   = 9'd300;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic eval;
        logic rd_nxt;
        logic inc_idx;
        logic hit_set;
        logic wr_move;
        logic dec_cnt;
        logic load_out;
    } kfl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_search;
        logic idx_lt_cnt;
        logic nxt_lt_cnt;
        logic nxt2_lt_cnt;
        logic hit;
        logic out_free;
    } kfl_sts_t;

endpackage

/* rtl/kfl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/kfl_ctrl.sv */
// Sequencer of the lock controller: accepts an item, steps the datapath
// through evaluation, list search and compaction, then hands off the result.
// Depends on kfl_pkg.
module kfl_ctrl
    import kfl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  kfl_sts_t sts,
    output kfl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EVAL     = 3'd1;
    localparam logic [2:0] S_SRCH_RD  = 3'd2;
    localparam logic [2:0] S_SRCH_CMP = 3'd3;
    localparam logic [2:0] S_MV_RD    = 3'd4;
    localparam logic [2:0] S_MV_WR    = 3'd5;
    localparam logic [2:0] S_FIN      = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.need_search ? S_SRCH_RD : S_FIN;
            end
            S_SRCH_RD:
            begin
                // The read address already points at the current entry.
                if (sts.idx_lt_cnt)
                begin
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SRCH_CMP:
            begin
                if (sts.hit)
                begin
                    cmd.hit_set = 1'b1;
                    if (sts.nxt_lt_cnt)
                    begin
                        state_next = S_MV_RD;
                    end
                    else
                    begin
                        cmd.dec_cnt = 1'b1;
                        state_next  = S_FIN;
                    end
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_MV_RD:
            begin
                cmd.rd_nxt = 1'b1;
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                cmd.wr_move = 1'b1;
                cmd.inc_idx = 1'b1;
                if (sts.nxt2_lt_cnt)
                begin
                    state_next = S_MV_RD;
                end
                else
                begin
                    cmd.dec_cnt = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/kfl_dp.sv */
// Datapath of the lock controller: configuration, mode and entry state,
// PIN buffer, ID list memory, result and output registers.
// Depends on kfl_pkg and kfl_ram.
module kfl_dp
    import kfl_pkg::*;
#(
    parameter int MAX_IDS       = 16,
    parameter int PIN_ENTRY_MAX = 9,
    parameter int ID_DIGITS     = 3,
    parameter int CNT_W         = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [63:0]      cfg_data,
    input  logic [1:0]       req_type,
    input  logic [7:0]       key_code,
    input  logic [ID_W-1:0]  finger_id,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [3:0]       status,
    output logic [2:0]       mode,
    output logic             open_pulse,
    output logic             close_pulse,
    output logic             timer_restart,
    output logic             enroll_request,
    output logic [ID_W-1:0]  enroll_fid,
    output logic [PC_W-1:0]  masked_count,
    output logic [IDV_W-1:0] id_entry_value,
    output logic             enrolling,
    output logic [CNT_W-1:0] id_count,
    input  kfl_cmd_t         cmd,
    output kfl_sts_t         sts
);

    localparam int AW     = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam int PB_AW  = (PIN_ENTRY_MAX > 1) ? $clog2(PIN_ENTRY_MAX) : 1;
    localparam int DC_W   = $clog2(ID_DIGITS + 1);
    localparam int PE_CMP = (PIN_ENTRY_MAX < 8) ? PIN_ENTRY_MAX : 8;

    // Configuration registers.
    logic [63:0] pin_chars_reg;
    logic [3:0]  pin_len_reg;
    logic [8:0]  id_limit_reg;

    // Captured item.
    logic [1:0]      req_reg;
    logic [7:0]      key_reg;
    logic [ID_W-1:0] fid_reg;

    // Persistent state.
    logic [2:0]       mode_reg, mode_next;
    logic [PC_W-1:0]  pin_cnt_reg, pin_cnt_next;
    logic [IDV_W-1:0] idv_reg, idv_next;
    logic [DC_W-1:0]  idc_reg, idc_next;
    logic [CNT_W-1:0] list_cnt_reg;
    logic [7:0]       pin_buf_reg [PIN_ENTRY_MAX];

    // Search state and pending result.
    logic [CNT_W-1:0] idx_reg;
    logic [IDV_W-1:0] del_id_reg, del_id_next;
    logic [3:0]       res_status_reg, res_status_next;
    logic             res_open_reg, res_open_next;
    logic             res_close_reg, res_close_next;
    logic             res_restart_reg, res_restart_next;
    logic             res_ereq_reg, res_ereq_next;
    logic [ID_W-1:0]  res_eid_reg, res_eid_next;

    // Output registers.
    logic             out_valid_reg;
    logic [3:0]       o_status_reg;
    logic [2:0]       o_mode_reg;
    logic             o_open_reg, o_close_reg, o_restart_reg, o_ereq_reg;
    logic [ID_W-1:0]  o_eid_reg;
    logic [PC_W-1:0]  o_masked_reg;
    logic [IDV_W-1:0] o_idv_reg;
    logic [CNT_W-1:0] o_cnt_reg;

    // Evaluation side signals.
    logic            pin_ok;
    logic            pb_we;
    logic            lst_we;
    logic            unlock;
    logic            need_search;
    logic            is_key;
    logic            is_digit;
    logic [3:0]      digit;
    logic            enroll;

    // Memory port signals.
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [ID_W-1:0] ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [ID_W-1:0] ram_rdata;
    logic [CNT_W:0]  idx_p1;
    logic [CNT_W:0]  idx_p2;

    assign is_key   = (req_reg == REQ_KEY);
    assign is_digit = is_key && (key_reg >= KEY_0) && (key_reg <= KEY_9);
    assign digit    = 4'(key_reg - KEY_0);
    assign enroll   = (mode_reg == MODE_ENROLL);
    assign idx_p1   = {1'b0, idx_reg} + 1'b1;
    assign idx_p2   = {1'b0, idx_reg} + 2'd2;

    // Entered PIN against the stored PIN, all bytes in parallel.
    always_comb
    begin
        pin_ok = (pin_cnt_reg == pin_len_reg) && (pin_len_reg <= 4'd8);
        for (int i = 0; i < PE_CMP; i++)
        begin
            if ((PC_W'(i) < pin_cnt_reg) && (pin_buf_reg[i] != pin_chars_reg[8*i +: 8]))
            begin
                pin_ok = 1'b0;
            end
        end
    end

    // Per-item decision on the captured item.
    always_comb
    begin
        mode_next        = mode_reg;
        pin_cnt_next     = pin_cnt_reg;
        idv_next         = idv_reg;
        idc_next         = idc_reg;
        del_id_next      = del_id_reg;
        res_status_next  = res_status_reg;
        res_open_next    = res_open_reg;
        res_close_next   = res_close_reg;
        res_restart_next = res_restart_reg;
        res_ereq_next    = res_ereq_reg;
        res_eid_next     = res_eid_reg;
        pb_we            = 1'b0;
        lst_we           = 1'b0;
        unlock           = 1'b0;
        need_search      = 1'b0;
        if (cmd.hit_set)
        begin
            res_status_next = STAT_DELETED;
        end
        if (cmd.eval)
        begin
            res_status_next  = STAT_NONE;
            res_open_next    = 1'b0;
            res_close_next   = 1'b0;
            res_restart_next = 1'b0;
            res_ereq_next    = 1'b0;
            res_eid_next     = '0;
            if (req_reg == REQ_AUTO)
            begin
                res_close_next  = 1'b1;
                res_status_next = STAT_AUTOLOCK;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (is_key && key_reg == KEY_A)
                        begin
                            mode_next       = MODE_FINGER;
                            pin_cnt_next    = '0;
                            res_status_next = STAT_FINGER;
                        end
                        else if (is_key && key_reg == KEY_B)
                        begin
                            mode_next       = MODE_PIN;
                            pin_cnt_next    = '0;
                            res_status_next = STAT_PIN;
                        end
                        else if (is_key && key_reg == KEY_C)
                        begin
                            mode_next       = MODE_MENU;
                            res_status_next = STAT_MENU;
                        end
                    end
                    MODE_FINGER:
                    begin
                        if (req_reg == REQ_MATCH && fid_reg != '0)
                        begin
                            unlock = 1'b1;
                        end
                        else if (req_reg == REQ_FAIL)
                        begin
                            res_status_next = STAT_FNG_BAD;
                        end
                        else if (is_key && key_reg == KEY_STAR)
                        begin
                            mode_next       = MODE_IDLE;
                            res_status_next = STAT_IDLE;
                        end
                    end
                    MODE_PIN:
                    begin
                        if (is_key)
                        begin
                            if (key_reg == KEY_STAR)
                            begin
                                mode_next       = MODE_IDLE;
                                pin_cnt_next    = '0;
                                res_status_next = STAT_IDLE;
                            end
                            else if (key_reg == KEY_D)
                            begin
                                if (pin_ok)
                                begin
                                    unlock = 1'b1;
                                end
                                else
                                begin
                                    res_status_next = STAT_PIN_BAD;
                                end
                                pin_cnt_next = '0;
                            end
                            else if (key_reg == KEY_C)
                            begin
                                pin_cnt_next    = '0;
                                res_status_next = STAT_CLEARED;
                            end
                            else if (pin_cnt_reg < PC_W'(PIN_ENTRY_MAX))
                            begin
                                pb_we           = 1'b1;
                                pin_cnt_next    = pin_cnt_reg + 1'b1;
                                res_status_next = STAT_DIGIT;
                            end
                        end
                    end
                    MODE_MENU:
                    begin
                        if (is_key)
                        begin
                            idv_next = '0;
                            idc_next = '0;
                            if (key_reg == KEY_A)
                            begin
                                mode_next = MODE_ENROLL;
                            end
                            else if (key_reg == KEY_B)
                            begin
                                mode_next = MODE_DELETE;
                            end
                            else
                            begin
                                mode_next       = MODE_IDLE;
                                res_status_next = STAT_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        // Enroll or delete ID entry.
                        if (is_digit && idc_reg < DC_W'(ID_DIGITS))
                        begin
                            idv_next = IDV_W'((idv_reg << 3) + (idv_reg << 1) + digit);
                            idc_next = idc_reg + 1'b1;
                            res_status_next = STAT_DIGIT;
                        end
                        else if (is_key && key_reg == KEY_C)
                        begin
                            idv_next        = '0;
                            idc_next        = '0;
                            res_status_next = STAT_CLEARED;
                        end
                        else if (is_key && enroll && key_reg == KEY_A)
                        begin
                            idv_next        = '0;
                            idc_next        = '0;
                            mode_next       = MODE_IDLE;
                            res_status_next = STAT_IDLE;
                        end
                        else if (is_key && key_reg == KEY_D)
                        begin
                            if (idc_reg == '0)
                            begin
                                res_status_next = STAT_IDLE;
                            end
                            else if (enroll)
                            begin
                                if (idv_reg >= 10'd1 && idv_reg <= {1'b0, id_limit_reg})
                                begin
                                    res_ereq_next = 1'b1;
                                    res_eid_next  = idv_reg[ID_W-1:0];
                                    if (list_cnt_reg < CNT_W'(MAX_IDS))
                                    begin
                                        lst_we          = 1'b1;
                                        res_status_next = STAT_ENROLL;
                                    end
                                    else
                                    begin
                                        res_status_next = STAT_FULL;
                                    end
                                end
                                else
                                begin
                                    res_status_next = STAT_ID_BAD;
                                end
                            end
                            else
                            begin
                                need_search     = 1'b1;
                                del_id_next     = idv_reg;
                                res_status_next = STAT_MISSING;
                            end
                            idv_next  = '0;
                            idc_next  = '0;
                            mode_next = MODE_IDLE;
                        end
                    end
                endcase
            end
            if (unlock)
            begin
                res_status_next  = STAT_UNLOCKED;
                res_open_next    = 1'b1;
                res_restart_next = 1'b1;
                mode_next        = MODE_IDLE;
            end
        end
    end

    // ID list memory: appends on enrollment, moves entries down on deletion.
    assign ram_we    = lst_we || cmd.wr_move;
    assign ram_waddr = cmd.wr_move ? idx_reg[AW-1:0] : list_cnt_reg[AW-1:0];
    assign ram_wdata = cmd.wr_move ? ram_rdata : idv_reg[ID_W-1:0];
    assign ram_raddr = cmd.rd_nxt ? idx_p1[AW-1:0] : idx_reg[AW-1:0];

    kfl_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_IDS),
        .AW    (AW)
    ) u_id_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Status toward the controller.
    assign sts.need_search = need_search;
    assign sts.idx_lt_cnt  = (idx_reg < list_cnt_reg);
    assign sts.nxt_lt_cnt  = (idx_p1 < {1'b0, list_cnt_reg});
    assign sts.nxt2_lt_cnt = (idx_p2 < {1'b0, list_cnt_reg});
    assign sts.hit         = ({1'b0, ram_rdata} == del_id_reg);
    assign sts.out_free    = !out_valid_reg || !out_stall;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_chars_reg <= PIN_CHARS_RST;
            pin_len_reg   <= PIN_LENGTH_RST;
            id_limit_reg  <= ID_LIMIT_RST;
            mode_reg      <= MODE_IDLE;
            pin_cnt_reg   <= '0;
            idv_reg       <= '0;
            idc_reg       <= '0;
            list_cnt_reg  <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PIN_CHARS:  pin_chars_reg <= cfg_data;
                    CFG_PIN_LENGTH: pin_len_reg   <= cfg_data[3:0];
                    CFG_ID_LIMIT:   id_limit_reg  <= cfg_data[8:0];
                    default:        ;
                endcase
            end
            mode_reg    <= mode_next;
            pin_cnt_reg <= pin_cnt_next;
            idv_reg     <= idv_next;
            idc_reg     <= idc_next;
            if (lst_we)
            begin
                list_cnt_reg <= list_cnt_reg + 1'b1;
            end
            else if (cmd.dec_cnt)
            begin
                list_cnt_reg <= list_cnt_reg - 1'b1;
            end
            if (cmd.eval)
            begin
                idx_reg <= '0;
            end
            else if (cmd.inc_idx)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_type;
            key_reg <= key_code;
            fid_reg <= finger_id;
        end
        if (pb_we)
        begin
            pin_buf_reg[pin_cnt_reg[PB_AW-1:0]] <= key_reg;
        end
        del_id_reg      <= del_id_next;
        res_status_reg  <= res_status_next;
        res_open_reg    <= res_open_next;
        res_close_reg   <= res_close_next;
        res_restart_reg <= res_restart_next;
        res_ereq_reg    <= res_ereq_next;
        res_eid_reg     <= res_eid_next;
        if (cmd.load_out)
        begin
            o_status_reg  <= res_status_reg;
            o_mode_reg    <= mode_reg;
            o_open_reg    <= res_open_reg;
            o_close_reg   <= res_close_reg;
            o_restart_reg <= res_restart_reg;
            o_ereq_reg    <= res_ereq_reg;
            o_eid_reg     <= res_eid_reg;
            o_masked_reg  <= pin_cnt_reg;
            o_idv_reg     <= idv_reg;
            o_cnt_reg     <= list_cnt_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = o_status_reg;
    assign mode           = o_mode_reg;
    assign open_pulse     = o_open_reg;
    assign close_pulse    = o_close_reg;
    assign timer_restart  = o_restart_reg;
    assign enroll_request = o_ereq_reg;
    assign enroll_fid     = o_eid_reg;
    assign masked_count   = o_masked_reg;
    assign id_entry_value = o_idv_reg;
    assign enrolling      = (o_mode_reg == MODE_ENROLL);
    assign id_count       = o_cnt_reg;

endmodule

/* rtl/keypad_fingerprint_lock_controller.sv */
// Keypad and fingerprint lock controller, top level.
// One item in: a keypad key, a fingerprint match or fail, or an auto-lock expiry.
// One item out per input item: status, mode, lock/timer/enroll pulses and counters.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the PIN, the PIN
// length and the ID limit; it must be used only while the block is idle, which
// the block itself does not enforce.
// A deletion walks the ID list in the sequencer, searching for the entry and
// moving each later entry down by one place.
// A new item is taken only once the sequencer is back in its idle step.
// One item is in work at a time; the next item is taken as soon as the result
// sits in the output register, even while the receiver stalls it.
// A stalled result holds its value; the sequencer waits in its final step
// until the output register is free.
// Reset clears mode, counters and the list length; PIN buffer and ID list
// contents are not cleared, since only entries below their counts are read.
// Depends on kfl_pkg, kfl_ctrl, kfl_dp and kfl_ram.
module keypad_fingerprint_lock_controller
    import kfl_pkg::*;
#(
    parameter int MAX_IDS       = 16,
    parameter int PIN_ENTRY_MAX = 9,
    parameter int ID_DIGITS     = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [63:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       req_type,
    input  logic [7:0]                       key_code,
    input  logic [ID_W-1:0]                  finger_id,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [3:0]                       status,
    output logic [2:0]                       mode,
    output logic                             open_pulse,
    output logic                             close_pulse,
    output logic                             timer_restart,
    output logic                             enroll_request,
    output logic [ID_W-1:0]                  enroll_fid,
    output logic [PC_W-1:0]                  masked_count,
    output logic [IDV_W-1:0]                 id_entry_value,
    output logic                             enrolling,
    output logic [$clog2(MAX_IDS + 1)-1:0]   id_count
);

    localparam int CNT_W = $clog2(MAX_IDS + 1);

    kfl_cmd_t cmd;
    kfl_sts_t sts;

    // Sequencer.
    kfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath.
    kfl_dp #(
        .MAX_IDS       (MAX_IDS),
        .PIN_ENTRY_MAX (PIN_ENTRY_MAX),
        .ID_DIGITS     (ID_DIGITS),
        .CNT_W         (CNT_W)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_type       (req_type),
        .key_code       (key_code),
        .finger_id      (finger_id),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .mode           (mode),
        .open_pulse     (open_pulse),
        .close_pulse    (close_pulse),
        .timer_restart  (timer_restart),
        .enroll_request (enroll_request),
        .enroll_fid     (enroll_fid),
        .masked_count   (masked_count),
        .id_entry_value (id_entry_value),
        .enrolling      (enrolling),
        .id_count       (id_count),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

/* rtl/kfl_checker.sv */
// Port-level checker of the lock controller, bound to the top level.
// Depends on kfl_pkg and keypad_fingerprint_lock_controller_defines.svh.
`include "keypad_fingerprint_lock_controller_defines.svh"

module kfl_checker
    import kfl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] status,
    input logic [2:0] mode,
    input logic       open_pulse,
    input logic       close_pulse,
    input logic       timer_restart,
    input logic       enrolling
);

    // A stalled result stays offered.
    `KFL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // An unlock opens the lock, restarts the timer and returns to idle.
    `KFL_ASSERT_NOW(a_unlock, out_valid && open_pulse,
        status == STAT_UNLOCKED && timer_restart && mode == MODE_IDLE)

    // Closing the lock only ever comes from an auto-lock item.
    `KFL_ASSERT_NOW(a_close, out_valid && close_pulse,
        status == STAT_AUTOLOCK && !open_pulse)

    // The enrolling flag follows the reported mode.
    `KFL_ASSERT_NOW(a_enrolling, out_valid && enrolling, mode == MODE_ENROLL)

endmodule

bind keypad_fingerprint_lock_controller kfl_checker u_kfl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .mode          (mode),
    .open_pulse    (open_pulse),
    .close_pulse   (close_pulse),
    .timer_restart (timer_restart),
    .enrolling     (enrolling)
);
